// File: rtl/assert_macros.svh
// Assertion macros used by the histogram matcher back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also active while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/rhm_pkg.sv
// Shared types and constants for the RGB histogram matcher.
package rhm_pkg;

  localparam int LEVELS              = 256;
  localparam int CHANNELS            = 3;
  localparam int BINS                = LEVELS * CHANNELS;
  localparam int ADDR_W              = $clog2(BINS);
  localparam int LEVEL_W             = $clog2(LEVELS);
  localparam int COUNT_WIDTH_DEFAULT = 20;
  localparam int QUEUE_DEPTH         = 4;
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);

  // Item kinds as they arrive on the input channel
  typedef enum logic [2:0] {
    KIND_CLEAR = 3'd0,
    KIND_REF   = 3'd1,
    KIND_SRC   = 3'd2,
    KIND_BUILD = 3'd3,
    KIND_REMAP = 3'd4
  } kind_e;

  // Operation codes handed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_REF   = 3'd1,
    OP_SRC   = 3'd2,
    OP_BUILD = 3'd3,
    OP_REMAP = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } item_t;

  typedef struct packed {
    logic [7:0] mapped_blue;
    logic [7:0] mapped_green;
    logic [7:0] mapped_red;
  } result_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cmd_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic sweeping;
  } back_status_t;

endpackage

// File: rtl/rhm_front.sv
// Front end: accepts input beats, decodes the kind, queues commands.
module rhm_front
  import rhm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  back_status_t status,
  input  logic         pixel_valid,
  output logic         pixel_stall,
  input  item_t        pixel,
  output logic         cmd_valid,
  input  logic         cmd_pop,
  output cmd_t         cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             full;
  logic             accept;
  logic             known;
  logic             push;
  logic             pop;
  cmd_t             decoded;

  // Decode kind; unused codes are dropped here
  always_comb begin
    known          = 1'b1;
    decoded.blue   = pixel.blue;
    decoded.green  = pixel.green;
    decoded.red    = pixel.red;
    decoded.op     = OP_CLEAR;
    unique case (pixel.kind)
      KIND_CLEAR: decoded.op = OP_CLEAR;
      KIND_REF:   decoded.op = OP_REF;
      KIND_SRC:   decoded.op = OP_SRC;
      KIND_BUILD: decoded.op = OP_BUILD;
      KIND_REMAP: decoded.op = OP_REMAP;
      default:    known = 1'b0;
    endcase
  end

  assign full        = (fill == CNT_W'(QUEUE_DEPTH));
  assign pixel_stall = full || status.sweeping;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = accept && known;
  assign cmd_valid   = (fill != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = queue[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// File: rtl/rhm_back.sv
// Back end: histogram memories, clearing, cumulative build, map search and remap.
module rhm_back
  import rhm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  output back_status_t status,
  input  logic         cmd_valid,
  output logic         cmd_pop,
  input  cmd_t         cmd,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result
);

  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_SWEEP   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_PIX_RD  = 10'b0000000100,
    S_PIX_WR  = 10'b0000001000,
    S_ACC     = 10'b0000010000,
    S_MREQ    = 10'b0000100000,
    S_MCMP    = 10'b0001000000,
    S_MAP_RD  = 10'b0010000000,
    S_MAP_CAP = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BINS - 1);
  localparam logic [ADDR_W-1:0] END_BIN  = ADDR_W'(BINS);
  localparam logic [1:0]        LAST_CH  = 2'(CHANNELS - 1);

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  state_e               state;
  logic [ADDR_W-1:0]    idx;
  logic [1:0]           chan;
  logic [LEVEL_W-1:0]   i_lvl;
  logic [LEVEL_W:0]     j_lvl;
  logic [COUNT_WIDTH-1:0] acc_ref;
  logic [COUNT_WIDTH-1:0] acc_src;
  cmd_t                 cur;
  logic [7:0]           res_b;
  logic [7:0]           res_g;
  logic [7:0]           res_r;

  logic [COUNT_WIDTH-1:0] ref_mem [BINS];
  logic [COUNT_WIDTH-1:0] src_mem [BINS];
  logic [7:0]             map_mem [BINS];
  logic [COUNT_WIDTH-1:0] ref_rd;
  logic [COUNT_WIDTH-1:0] src_rd;
  logic [7:0]             map_rd;

  logic                   ref_we, src_we, map_we;
  logic [ADDR_W-1:0]      ref_waddr, src_waddr, map_waddr;
  logic [COUNT_WIDTH-1:0] ref_wdata, src_wdata;
  logic [7:0]             map_wdata;
  logic [ADDR_W-1:0]      ref_raddr, src_raddr, map_raddr;
  logic                   ref_re, src_re;

  logic [7:0]             lvl;
  logic [ADDR_W-1:0]      pix_addr;
  logic [ADDR_W-1:0]      prev_idx;
  logic                   chan_start;
  logic [COUNT_WIDTH-1:0] sum_ref, sum_src;
  logic                   found;
  logic                   out_load;

  assign status.sweeping = (state == S_SWEEP);
  assign cmd_pop         = (state == S_IDLE) && cmd_valid;
  assign out_load        = (state == S_OUT) && (!result_valid || !result_stall);

  // Per-channel level and bin address of the current beat
  always_comb begin
    case (chan)
      2'd0:    lvl = cur.blue;
      2'd1:    lvl = cur.green;
      default: lvl = cur.red;
    endcase
  end
  assign pix_addr = {chan, lvl};

  // Cumulative pass: write back bin idx-1, restart sum at each channel
  assign prev_idx   = idx - 1'b1;
  assign chan_start = (prev_idx[LEVEL_W-1:0] == '0);
  assign sum_ref    = sat_add(ref_rd, chan_start ? '0 : acc_ref);
  assign sum_src    = sat_add(src_rd, chan_start ? '0 : acc_src);

  // Match step: first reference level whose count exceeds source count
  assign found = j_lvl[LEVEL_W] || (ref_rd > src_rd);

  // Read addresses
  always_comb begin
    ref_raddr = pix_addr;
    src_raddr = pix_addr;
    ref_re    = 1'b1;
    src_re    = 1'b1;
    case (state)
      S_ACC: begin
        ref_raddr = idx;
        src_raddr = idx;
        ref_re    = (idx != END_BIN);
        src_re    = (idx != END_BIN);
      end
      S_MREQ: begin
        ref_raddr = {chan, j_lvl[LEVEL_W-1:0]};
        src_raddr = {chan, i_lvl};
      end
      default: ;
    endcase
  end
  assign map_raddr = pix_addr;

  // Write ports
  always_comb begin
    ref_we    = 1'b0;
    src_we    = 1'b0;
    map_we    = 1'b0;
    ref_waddr = idx;
    src_waddr = idx;
    ref_wdata = '0;
    src_wdata = '0;
    map_waddr = {chan, i_lvl};
    map_wdata = j_lvl[LEVEL_W] ? TOP_LEVEL : j_lvl[LEVEL_W-1:0];
    case (state)
      S_SWEEP: begin
        ref_we = 1'b1;
        src_we = 1'b1;
      end
      S_PIX_WR: begin
        ref_waddr = pix_addr;
        src_waddr = pix_addr;
        ref_wdata = sat_add(ref_rd, COUNT_WIDTH'(1));
        src_wdata = sat_add(src_rd, COUNT_WIDTH'(1));
        ref_we    = (cur.op == OP_REF);
        src_we    = (cur.op == OP_SRC);
      end
      S_ACC: begin
        ref_waddr = prev_idx;
        src_waddr = prev_idx;
        ref_wdata = sum_ref;
        src_wdata = sum_src;
        ref_we    = (idx != '0);
        src_we    = (idx != '0);
      end
      S_MCMP: map_we = found;
      default: ;
    endcase
  end

  // Histogram and map memories
  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (src_we) src_mem[src_waddr] <= src_wdata;
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (ref_re) ref_rd <= ref_mem[ref_raddr];
    if (src_re) src_rd <= src_mem[src_raddr];
    map_rd <= map_mem[map_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      idx   <= '0;
      chan  <= '0;
      i_lvl <= '0;
      j_lvl <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          idx <= idx + 1'b1;
          if (idx == LAST_BIN) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            chan  <= '0;
            idx   <= '0;
            i_lvl <= '0;
            j_lvl <= '0;
            unique case (cmd.op) inside
              OP_CLEAR:        state <= S_SWEEP;
              OP_REF, OP_SRC:  state <= S_PIX_RD;
              OP_BUILD:        state <= S_ACC;
              OP_REMAP:        state <= S_MAP_RD;
              default:         state <= S_IDLE;
            endcase
          end
        end
        S_PIX_RD: state <= S_PIX_WR;
        S_PIX_WR: begin
          chan  <= chan + 1'b1;
          state <= (chan == LAST_CH) ? S_IDLE : S_PIX_RD;
        end
        S_ACC: begin
          if (idx != '0) begin
            acc_ref <= sum_ref;
            acc_src <= sum_src;
          end
          idx <= idx + 1'b1;
          if (idx == END_BIN) begin
            idx   <= '0;
            state <= S_MREQ;
          end
        end
        S_MREQ: state <= S_MCMP;
        S_MCMP: begin
          state <= S_MREQ;
          if (found) begin
            i_lvl <= i_lvl + 1'b1;
            if (i_lvl == TOP_LEVEL) begin
              j_lvl <= '0;
              chan  <= chan + 1'b1;
              if (chan == LAST_CH) state <= S_IDLE;
            end
          end else begin
            j_lvl <= j_lvl + 1'b1;
          end
        end
        S_MAP_RD: state <= S_MAP_CAP;
        S_MAP_CAP: begin
          case (chan)
            2'd0:    res_b <= map_rd;
            2'd1:    res_g <= map_rd;
            default: res_r <= map_rd;
          endcase
          chan  <= chan + 1'b1;
          state <= (chan == LAST_CH) ? S_OUT : S_MAP_RD;
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.mapped_blue  <= res_b;
      result.mapped_green <= res_g;
      result.mapped_red   <= res_r;
    end
  end

  `ASSERT_CLK(a_pop_idle, clk, rst, cmd_pop |-> state == S_IDLE, "pop outside idle")
  `ASSERT_CLK(a_j_range, clk, rst, state == S_MCMP |-> j_lvl <= 9'(LEVELS),
              "search ran past top level")
  `ASSERT_CLK(a_out_free, clk, rst, out_load |-> (!result_valid || !result_stall),
              "result overwritten while stalled")
  `ASSERT_CLK(a_sweep_hold, clk, rst, status.sweeping |-> !cmd_pop, "pop during sweep")

endmodule

// File: rtl/rgb_histogram_matcher.sv
// Top level of the RGB histogram matcher.
//   channel  | handshake                    | beat
//   pixel    | pixel_valid / pixel_stall    | item_t (kind, blue, green, red)
//   result   | result_valid / result_stall  | result_t (mapped_blue/green/red)
// Pixel beats read-modify-write one bin per channel (S_PIX_RD, then S_PIX_WR).
// Remap beats read the map per channel, then wait in S_OUT while the result is stalled; result goes out via a register.
// Build runs an accumulation pass over all 768 bins, then a search of
// S_MREQ/S_MCMP steps per channel; clear writes zeros to all 768 bins.
// After reset a clearing pass over all bins runs with pixel_stall high.
// A 4-entry command queue lets pixels be taken while the back end works, except during a clearing pass.
module rgb_histogram_matcher
  import rhm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  output logic    pixel_stall,
  input  item_t   pixel,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  back_status_t status;
  logic         cmd_valid;
  logic         cmd_pop;
  cmd_t         cmd;

  rhm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .status      (status),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd)
  );

  rhm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .status       (status),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
